>>> rtl/fltw_pkg.sv
// ----------------------------------------------------------------------------
// fltw_pkg: shared types and constants of the four-level page table walker
// Store geometry, status codes, transfer payloads, controller commands and
// datapath status.
// ----------------------------------------------------------------------------
package fltw_pkg;

  localparam int TABLES     = 64;
  localparam int DEMAND_BIT = 9;

  localparam int IDX_W   = 9;
  localparam int ENTRIES = 1 << IDX_W;
  localparam int SLOT_W  = $clog2(TABLES);
  localparam int CNT_W   = $clog2(TABLES + 1);
  localparam int ADDR_W  = SLOT_W + IDX_W;
  localparam int DEPTH   = TABLES * ENTRIES;
  localparam int ROOT_W  = 6;

  localparam logic FUNC_LOOKUP = 1'b0;
  localparam logic FUNC_MAP    = 1'b1;

  localparam logic [2:0] STS_OK       = 3'd0;
  localparam logic [2:0] STS_NOTMAP   = 3'd1;
  localparam logic [2:0] STS_NONCANON = 3'd2;
  localparam logic [2:0] STS_EXHAUST  = 3'd3;
  localparam logic [2:0] STS_BADREF   = 3'd4;

  typedef struct packed {
    logic        func;
    logic [63:0] virt_addr;
    logic [51:0] phys_frame;
    logic [11:0] page_flags;
  } req_t;

  typedef struct packed {
    logic [63:0] leaf_entry;
    logic [2:0]  status;
  } rsp_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CHECK,
    ST_READ,
    ST_EVAL,
    ST_ALLOC,
    ST_ZERO,
    ST_LINK,
    ST_LEAF,
    ST_LEAF_WAIT,
    ST_DONE
  } st_t;

  typedef enum logic [2:0] {
    MEM_NONE,
    MEM_READ,
    MEM_CLR,
    MEM_ZERO,
    MEM_LINK,
    MEM_LEAF
  } mem_op_t;

  typedef struct packed {
    logic       load;
    logic       finish;
    logic [2:0] fin_status;
    logic       alloc;
    logic       advance;
    logic       adv_fresh;
    logic       sweep_start;
    mem_op_t    mem_op;
    logic       emit;
  } ctl_cmd_t;

  typedef struct packed {
    logic is_map;
    logic canon_err;
    logic root_err;
    logic present;
    logic walk_ok;
    logic nxt_err;
    logic alloc_fail;
    logic level_last;
    logic row_last;
    logic store_last;
    logic out_free;
  } dp_stat_t;

endpackage

>>> rtl/fltw_ctrl.sv
// ----------------------------------------------------------------------------
// fltw_ctrl: walk sequencer
// Steps the datapath through the clearing pass, the four table levels, table
// allocation and the result transfer.
// ----------------------------------------------------------------------------
module fltw_ctrl import fltw_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  input  dp_stat_t stat,
  output ctl_cmd_t cmd
);

  st_t state;
  st_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (stat.store_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) state_next = ST_CHECK;
      end
      ST_CHECK: begin
        if (stat.canon_err || stat.root_err) state_next = ST_DONE;
        else state_next = ST_READ;
      end
      ST_READ: state_next = ST_EVAL;
      ST_EVAL: begin
        if (stat.is_map && !stat.present) begin
          state_next = ST_ALLOC;
        end else if ((!stat.is_map && !stat.walk_ok) || stat.nxt_err) begin
          state_next = ST_DONE;
        end else if (stat.level_last) begin
          state_next = ST_LEAF;
        end else begin
          state_next = ST_READ;
        end
      end
      ST_ALLOC: begin
        if (stat.alloc_fail) state_next = ST_DONE;
        else state_next = ST_ZERO;
      end
      ST_ZERO: begin
        if (stat.row_last) state_next = ST_LINK;
      end
      ST_LINK: begin
        if (stat.level_last) state_next = ST_LEAF;
        else state_next = ST_READ;
      end
      ST_LEAF: begin
        if (stat.is_map) state_next = ST_DONE;
        else state_next = ST_LEAF_WAIT;
      end
      ST_LEAF_WAIT: state_next = ST_DONE;
      ST_DONE: begin
        if (stat.out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd          = '0;
    cmd.mem_op   = MEM_NONE;
    in_stall     = 1'b1;
    unique case (state)
      ST_CLEAR: cmd.mem_op = MEM_CLR;
      ST_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      ST_CHECK: begin
        if (stat.canon_err) begin
          cmd.finish     = 1'b1;
          cmd.fin_status = STS_NONCANON;
        end else if (stat.root_err) begin
          cmd.finish     = 1'b1;
          cmd.fin_status = STS_BADREF;
        end
      end
      ST_READ: cmd.mem_op = MEM_READ;
      ST_EVAL: begin
        if (stat.is_map && !stat.present) begin
          cmd.finish = 1'b0;
        end else if (!stat.is_map && !stat.walk_ok) begin
          cmd.finish     = 1'b1;
          cmd.fin_status = STS_NOTMAP;
        end else if (stat.nxt_err) begin
          cmd.finish     = 1'b1;
          cmd.fin_status = STS_BADREF;
        end else begin
          cmd.advance = 1'b1;
        end
      end
      ST_ALLOC: begin
        cmd.alloc       = 1'b1;
        cmd.sweep_start = 1'b1;
        if (stat.alloc_fail) begin
          cmd.finish     = 1'b1;
          cmd.fin_status = STS_EXHAUST;
        end
      end
      ST_ZERO: cmd.mem_op = MEM_ZERO;
      ST_LINK: begin
        cmd.mem_op    = MEM_LINK;
        cmd.advance   = 1'b1;
        cmd.adv_fresh = 1'b1;
      end
      ST_LEAF: begin
        if (stat.is_map) begin
          cmd.mem_op     = MEM_LEAF;
          cmd.finish     = 1'b1;
          cmd.fin_status = STS_OK;
        end else begin
          cmd.mem_op = MEM_READ;
        end
      end
      ST_LEAF_WAIT: begin
        cmd.finish     = 1'b1;
        cmd.fin_status = STS_OK;
      end
      ST_DONE: cmd.emit = stat.out_free;
      default: cmd.mem_op = MEM_NONE;
    endcase
  end

endmodule

>>> rtl/fltw_dpath.sv
// ----------------------------------------------------------------------------
// fltw_dpath: walker datapath
// Table store, walk registers, slot allocator, root register and the output
// register.
// ----------------------------------------------------------------------------
module fltw_dpath import fltw_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_write,
  input  logic [ROOT_W-1:0] cfg_data,
  input  req_t              in_data,
  input  ctl_cmd_t          cmd,
  output dp_stat_t          stat,
  output logic              out_valid,
  input  logic              out_stall,
  output rsp_t              out_data
);

  logic [63:0]       store [DEPTH];

  req_t              item;
  logic [ROOT_W-1:0] root;
  logic [SLOT_W-1:0] slot;
  logic [1:0]        level;
  logic [63:0]       rdata;
  logic [SLOT_W-1:0] fresh;
  logic [CNT_W-1:0]  next_free_slot;
  logic [ADDR_W-1:0] sweep;
  logic [63:0]       res_leaf;
  logic [2:0]        res_status;

  logic [IDX_W-1:0]  idx;
  logic [35:0]       nxt;
  logic [CNT_W-1:0]  nfs_skip;
  logic [63:0]       link_entry;
  logic [63:0]       map_leaf;
  logic [16:0]       va_top;
  logic              mem_we;
  logic              mem_re;
  logic [ADDR_W-1:0] mem_addr;
  logic [63:0]       mem_wdata;

  always_comb begin
    case (level)
      2'd0:    idx = item.virt_addr[47:39];
      2'd1:    idx = item.virt_addr[38:30];
      2'd2:    idx = item.virt_addr[29:21];
      default: idx = item.virt_addr[20:12];
    endcase
  end

  assign nxt        = rdata[47:12];
  assign link_entry = 64'({fresh, item.page_flags});
  assign map_leaf   = {item.phys_frame, item.page_flags};
  assign va_top     = item.virt_addr[63:47];

  // The allocator steps over the slot that currently serves as root.
  always_comb begin
    if ((next_free_slot < CNT_W'(TABLES)) && (64'(next_free_slot) == 64'(root))) begin
      nfs_skip = next_free_slot + CNT_W'(1);
    end else begin
      nfs_skip = next_free_slot;
    end
  end

  always_comb begin
    stat.is_map     = (item.func == FUNC_MAP);
    stat.canon_err  = stat.is_map ? ((va_top != '0) && (va_top != '1))
                                  : item.virt_addr[47];
    stat.root_err   = 64'(root) >= 64'(TABLES);
    stat.present    = rdata[0];
    stat.walk_ok    = rdata[0] || rdata[DEMAND_BIT];
    stat.nxt_err    = nxt >= 36'(TABLES);
    stat.alloc_fail = nfs_skip >= CNT_W'(TABLES);
    stat.level_last = (level == 2'd2);
    stat.row_last   = (sweep[IDX_W-1:0] == '1);
    stat.store_last = (sweep == ADDR_W'(DEPTH - 1));
    stat.out_free   = !out_valid || !out_stall;
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_addr  = {slot, idx};
    mem_wdata = '0;
    unique case (cmd.mem_op)
      MEM_NONE: mem_we = 1'b0;
      MEM_READ: mem_re = 1'b1;
      MEM_CLR: begin
        mem_we   = 1'b1;
        mem_addr = sweep;
      end
      MEM_ZERO: begin
        mem_we   = 1'b1;
        mem_addr = {fresh, sweep[IDX_W-1:0]};
      end
      MEM_LINK: begin
        mem_we    = 1'b1;
        mem_wdata = link_entry;
      end
      MEM_LEAF: begin
        mem_we    = 1'b1;
        mem_wdata = map_leaf;
      end
      default: mem_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      store[mem_addr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata <= store[mem_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      root           <= '0;
      next_free_slot <= '0;
      sweep          <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (cfg_write) begin
        root <= cfg_data;
      end
      if (cmd.alloc) begin
        next_free_slot <= stat.alloc_fail ? nfs_skip : nfs_skip + CNT_W'(1);
      end
      if (cmd.sweep_start) begin
        sweep <= '0;
      end else if (cmd.mem_op == MEM_CLR || cmd.mem_op == MEM_ZERO) begin
        sweep <= sweep + ADDR_W'(1);
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item  <= in_data;
      slot  <= SLOT_W'(root);
      level <= 2'd0;
    end else if (cmd.advance) begin
      slot  <= cmd.adv_fresh ? fresh : nxt[SLOT_W-1:0];
      level <= level + 2'd1;
    end
    if (cmd.alloc) begin
      fresh <= nfs_skip[SLOT_W-1:0];
    end
    if (cmd.finish) begin
      res_status <= cmd.fin_status;
      if (cmd.fin_status != STS_OK) begin
        res_leaf <= '0;
      end else begin
        res_leaf <= stat.is_map ? map_leaf : rdata;
      end
    end
    if (cmd.emit) begin
      out_data.leaf_entry <= res_leaf;
      out_data.status     <= res_status;
    end
  end

endmodule

>>> rtl/four_level_page_table_map_walk_core.sv
// ----------------------------------------------------------------------------
// four_level_page_table_map_walk_core: four-level page table map and lookup
// Walks a local store of page tables to map a page or look up a leaf entry.
//
// The request channel (in_valid, in_stall, in_data) carries one map or lookup
// per transfer; the response channel (out_valid, out_stall, out_data) returns
// one leaf entry and status per request. cfg_write/cfg_data set the root
// table slot and are to be used only while the walker is idle; the block
// itself does not enforce this. One request is worked at a time. A map
// zeroes each table that it has to allocate, one entry a cycle through the
// single-port store. Each level costs a read and a registered evaluation.
// After reset the store is cleared in a pass over its TABLES*512 entries
// (32768 at 64 tables), during which in_stall stays high. The response
// sits in an output register, so the next request is taken while a stalled
// response waits; that request's own response then waits until the
// register is free.
// ----------------------------------------------------------------------------
module four_level_page_table_map_walk_core import fltw_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_write,
  input  logic [ROOT_W-1:0] cfg_data,
  input  logic              in_valid,
  output logic              in_stall,
  input  req_t              in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output rsp_t              out_data
);

  ctl_cmd_t cmd;
  dp_stat_t stat;

  fltw_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  fltw_dpath u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

>>> tb/sv/four_level_page_table_map_walk_checker.sv
// ----------------------------------------------------------------------------
// four_level_page_table_map_walk_checker: response checker for the walker
// Watches the root register writes and both transfer channels, keeps its own
// image of the page table store, predicts each response and compares it.
// ----------------------------------------------------------------------------
module four_level_page_table_map_walk_checker import fltw_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_write,
  input  logic [ROOT_W-1:0] cfg_data,
  input  logic              in_valid,
  input  logic              in_stall,
  input  req_t              in_data,
  input  logic              out_valid,
  input  logic              out_stall,
  input  rsp_t              out_data,
  output int                fail_count,
  output int                pending
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [63:0]       table_image [DEPTH];
  int unsigned       alloc_next;
  logic [ROOT_W-1:0] root_slot;
  rsp_t              due_responses [$];

  // Walks the image exactly as the block should, updating it for a map.
  function automatic rsp_t walk_page_tables(input req_t rq);
    rsp_t        r;
    int unsigned slot;
    int unsigned idx;
    int unsigned fresh;
    logic [63:0] ent;
    r.leaf_entry = '0;
    r.status     = STS_OK;
    slot         = 32'(root_slot);
    if (rq.func == FUNC_MAP) begin
      if (rq.virt_addr[63:47] != '0 && rq.virt_addr[63:47] != '1) begin
        r.status = STS_NONCANON;
        return r;
      end
    end else if (rq.virt_addr[47]) begin
      r.status = STS_NONCANON;
      return r;
    end
    if (slot >= TABLES) begin
      r.status = STS_BADREF;
      return r;
    end
    for (int lvl = 0; lvl < 3; lvl++) begin
      idx = 32'(rq.virt_addr[(39 - 9 * lvl) +: IDX_W]);
      ent = table_image[slot * ENTRIES + idx];
      if (rq.func == FUNC_MAP) begin
        if (!ent[0]) begin
          // The allocator never hands out the slot of the active root.
          if (alloc_next < TABLES && alloc_next == root_slot) alloc_next++;
          if (alloc_next >= TABLES) begin
            r.status = STS_EXHAUST;
            return r;
          end
          fresh = alloc_next;
          alloc_next++;
          for (int k = 0; k < ENTRIES; k++) table_image[fresh * ENTRIES + k] = '0;
          ent = (64'(fresh) << 12) | 64'(rq.page_flags);
          table_image[slot * ENTRIES + idx] = ent;
        end
      end else if (!ent[0] && !ent[DEMAND_BIT]) begin
        r.status = STS_NOTMAP;
        return r;
      end
      if (ent[47:12] >= TABLES) begin
        r.status = STS_BADREF;
        return r;
      end
      slot = 32'(ent[12 +: SLOT_W]);
    end
    idx = 32'(rq.virt_addr[20:12]);
    if (rq.func == FUNC_MAP) begin
      r.leaf_entry = {rq.phys_frame, rq.page_flags};
      table_image[slot * ENTRIES + idx] = r.leaf_entry;
    end else begin
      r.leaf_entry = table_image[slot * ENTRIES + idx];
    end
    return r;
  endfunction

  always @(posedge clk) begin
    rsp_t want;
    if (rst) begin
      for (int i = 0; i < DEPTH; i++) table_image[i] = '0;
      alloc_next = 0;
      root_slot  = '0;
      fail_count = 0;
      due_responses.delete();
    end else begin
      if (cfg_write) root_slot = cfg_data;
      if (in_valid && !in_stall) due_responses.push_back(walk_page_tables(in_data));
      if (out_valid && !out_stall) begin
        if (due_responses.size() == 0) begin
          $error("unexpected response transfer: leaf_entry %h status %0d",
                 out_data.leaf_entry, out_data.status);
          fail_count++;
        end else begin
          want = due_responses.pop_front();
          if (out_data.leaf_entry !== want.leaf_entry) begin
            $error("leaf_entry mismatch: expected %h, actual %h",
                   want.leaf_entry, out_data.leaf_entry);
            fail_count++;
          end
          if (out_data.status !== want.status) begin
            $error("status mismatch: expected %0d, actual %0d",
                   want.status, out_data.status);
            fail_count++;
          end
        end
      end
    end
    pending = due_responses.size();
  end

endmodule

>>> tb/sv/four_level_page_table_map_walk_core_tb.sv
// ----------------------------------------------------------------------------
// four_level_page_table_map_walk_core_tb: testbench of the page table walker
// Drives directed and random map and lookup requests under several root
// table settings, with bursty requests and a stalling response side, and
// leaves prediction and comparison to the checker beside the block.
// ----------------------------------------------------------------------------
module four_level_page_table_map_walk_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import fltw_pkg::*;

  localparam int QUIET_LIMIT = 200000;
  localparam int HOLD_CYCLES = 400;

  logic              clk;
  logic              rst;
  logic              cfg_write;
  logic [ROOT_W-1:0] cfg_data;
  logic              in_valid;
  logic              in_stall;
  req_t              in_data;
  logic              out_valid;
  logic              out_stall;
  rsp_t              out_data;
  int                fail_count;
  int                pending;

  bit                hold_off_req = 1'b0;
  bit                gaps_on;
  int unsigned       burst_left;
  int                quiet_cycles;

  four_level_page_table_map_walk_core dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  four_level_page_table_map_walk_checker checker_inst (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic req_t build_req(input logic func, input logic [63:0] va,
                                     input logic [51:0] frame, input logic [11:0] flags);
    req_t rq;
    rq.func       = func;
    rq.virt_addr  = va;
    rq.phys_frame = frame;
    rq.page_flags = flags;
    return rq;
  endfunction

  // Upper-level indices come from a few values so that paths are shared.
  function automatic logic [8:0] pool_index();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return 9'd0;
      4, 5:       return 9'd1;
      6:          return 9'h1FF;
      7:          return 9'd2;
      default:    return 9'($urandom_range(0, 3));
    endcase
  endfunction

  function automatic logic [63:0] pool_vaddr();
    logic [8:0]  i0;
    logic [8:0]  i1;
    logic [8:0]  i2;
    logic [8:0]  i3;
    logic [47:0] low;
    i0  = pool_index();
    i1  = pool_index();
    i2  = pool_index();
    i3  = ($urandom_range(0, 3) == 0) ? 9'($urandom) : 9'($urandom_range(0, 7));
    low = {i0, i1, i2, i3, 12'($urandom)};
    return {{16{low[47]}}, low};
  endfunction

  function automatic req_t random_request();
    req_t        rq;
    int unsigned pick;
    pick          = $urandom_range(0, 99);
    rq.phys_frame = {20'($urandom), 32'($urandom)};
    rq.page_flags = 12'($urandom);
    // Small frames turn leaf entries into valid slot references.
    if ($urandom_range(0, 3) == 0) rq.phys_frame = 52'($urandom_range(0, 63));
    if (pick < 15) begin
      rq.func      = 1'($urandom);
      rq.virt_addr = {$urandom, $urandom};
    end else begin
      rq.func      = (pick < 60) ? FUNC_MAP : FUNC_LOOKUP;
      rq.virt_addr = pool_vaddr();
      if ($urandom_range(0, 6) != 0) rq.page_flags[0] = 1'b1;
    end
    return rq;
  endfunction

  // Holds the request until its transfer, then either keeps the burst going
  // or idles for a random gap.
  task automatic offer(input req_t rq);
    in_valid <= 1'b1;
    in_data  <= rq;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    if (!gaps_on || burst_left > 0) begin
      if (burst_left > 0) burst_left--;
    end else begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
      burst_left = $urandom_range(0, 30);
    end
  endtask

  task automatic set_root(input logic [ROOT_W-1:0] slot);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_data  <= slot;
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic run_random(input int unsigned count);
    gaps_on = ($urandom_range(0, 3) != 0);
    for (int n = 0; n < count; n++) offer(random_request());
  endtask

  initial begin
    rst        = 1'b1;
    cfg_write  = 1'b0;
    cfg_data   = '0;
    in_valid   = 1'b0;
    in_data    = '0;
    gaps_on    = 1'b1;
    burst_left = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Empty store, errors on the address, then a first full mapping.
    offer(build_req(FUNC_LOOKUP, 64'h0, 52'h0, 12'h0));
    offer(build_req(FUNC_LOOKUP, 64'h0000_8000_0000_0000, 52'h0, 12'h0));
    offer(build_req(FUNC_LOOKUP, '1, '1, '1));
    offer(build_req(FUNC_MAP, 64'h0001_0000_0000_0000, 52'h1, 12'h1));
    offer(build_req(FUNC_MAP, 64'h8000_0000_0000_0000, 52'h1, 12'h1));
    offer(build_req(FUNC_MAP, 64'h0, '1, 12'hFFF));
    offer(build_req(FUNC_LOOKUP, 64'h0000_0000_0000_0FFF, 52'h0, 12'h0));
    offer(build_req(FUNC_MAP, 64'hFFFF_FFFF_FFFF_F000, 52'h0, 12'h001));
    offer(build_req(FUNC_LOOKUP, 64'h0000_7FFF_FFFF_F000, 52'h0, 12'h0));
    // Demand-marked but not present: lookup follows, a second map reallocates.
    offer(build_req(FUNC_MAP, 64'h0000_0080_0000_0000, 52'h3, 12'h200));
    offer(build_req(FUNC_LOOKUP, 64'h0000_0080_0000_0000, 52'h0, 12'h0));
    offer(build_req(FUNC_MAP, 64'h0000_0080_0000_0000, 52'h5, 12'h200));
    offer(build_req(FUNC_MAP, 64'h0000_0100_0000_0000, 52'h7, 12'h000));
    offer(build_req(FUNC_LOOKUP, 64'h0000_0100_0000_0000, 52'h0, 12'h0));
    offer(build_req(FUNC_MAP, 64'h0000_0000_0000_1000, 52'h1, 12'h001));
    offer(build_req(FUNC_LOOKUP, 64'h0000_0000_0000_1000, 52'h0, 12'h0));

    // Slot 3 holds the leaf table of address zero, so its entries name
    // frames rather than tables.
    set_root(6'd3);
    offer(build_req(FUNC_LOOKUP, 64'h0, 52'h0, 12'h0));
    offer(build_req(FUNC_MAP, 64'h0, 52'h9, 12'h001));
    offer(build_req(FUNC_LOOKUP, 64'h0000_0080_0000_0000, 52'h0, 12'h0));
    offer(build_req(FUNC_MAP, 64'h0000_0380_0000_0000, 52'h11, 12'h201));

    set_root(6'd0);
    hold_off_req = 1'b1;
    run_random(420);
    set_root(6'd63);
    run_random(220);
    set_root(6'($urandom_range(1, 62)));
    run_random(220);
    set_root(6'd0);
    run_random(280);

    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (40) @(negedge clk);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Response side: stall density changes per epoch, plus one long hold-off
  // that backs the walker up into its request channel.
  initial begin
    int unsigned epoch_left;
    int unsigned stall_pct;
    out_stall  = 1'b0;
    epoch_left = 0;
    stall_pct  = 0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      if (epoch_left == 0) begin
        epoch_left = $urandom_range(20, 300);
        case ($urandom_range(0, 3))
          0:       stall_pct = 0;
          1:       stall_pct = 20;
          2:       stall_pct = 50;
          default: stall_pct = 85;
        endcase
      end
      epoch_left--;
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // The clearing pass after reset is the longest legal stretch without a
  // transfer; the limit is several times that.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_write) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == QUIET_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

endmodule

>>> files.f
rtl/fltw_pkg.sv
rtl/fltw_ctrl.sv
rtl/fltw_dpath.sv
rtl/four_level_page_table_map_walk_core.sv
tb/sv/four_level_page_table_map_walk_checker.sv
tb/sv/four_level_page_table_map_walk_core_tb.sv
